[src/dwsi_pkg.sv]
`timescale 1ns / 1ps

package dwsi_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = $clog2(Depth + 1);

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [CountW-1:0]       count_t;

  typedef enum logic [1:0] {
    ActAppend    = 2'd0,
    ActInsert    = 2'd1,
    ActPopFront  = 2'd2,
    ActPopBack   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CmdHold     = 2'd0,
    CmdInsert   = 2'd1,
    CmdShiftOut = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     sorted;
    word_t    value;
  } cell_cmd_t;

  typedef struct packed {
    logic occupied;
    logic at_count;
    logic is_last;
  } cell_pos_t;

endpackage

[src/dwsi_in_if.sv]
`timescale 1ns / 1ps

interface dwsi_in_if import dwsi_pkg::*; ();

  logic              valid;
  logic              ready;
  action_e           action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);

endinterface

[src/dwsi_out_if.sv]
`timescale 1ns / 1ps

interface dwsi_out_if import dwsi_pkg::*; ();

  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic [4:0]         count;

  modport source (output valid, output popped_value, output status, output count, input ready);
  modport sink   (input valid, input popped_value, input status, input count, output ready);

endinterface

[src/dwsi_cell.sv]
`timescale 1ns / 1ps

module dwsi_cell import dwsi_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  cell_pos_t pos_i,
  input  word_t     left_entry_i,
  input  word_t     right_entry_i,
  input  logic      found_i,
  output logic      found_o,
  input  word_t     tail_i,
  output word_t     tail_o,
  output word_t     entry_o
);

  word_t entry_q;
  word_t entry_d;
  logic  less;

  assign less    = cmd_i.sorted && pos_i.occupied && (entry_q < cmd_i.value);
  assign found_o = found_i || less;
  assign tail_o  = pos_i.is_last ? (tail_i | entry_q) : tail_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      CmdInsert: begin
        if (found_i) begin
          entry_d = left_entry_i;
        end else if (less || pos_i.at_count) begin
          entry_d = cmd_i.value;
        end
      end
      CmdShiftOut: entry_d = right_entry_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[src/deque_with_sorted_insert_unit.sv]
`timescale 1ns / 1ps

// Deque of up to sixteen signed words with append, priority insert, pop front and pop back.
// Every word moves one result word, and a new word is taken in every cycle while the result
// register is free or being drained, so one action completes per clock. The entries live in
// a row of cells, and a priority insert finds its place through a compare chain that ripples
// from the front cell to the back cell, which sets the longest path of the design.

module deque_with_sorted_insert_unit import dwsi_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  dwsi_in_if.sink    in_i,
  dwsi_out_if.source out_o
);

  count_t    count_q;
  count_t    count_d;
  logic      out_valid_q;
  word_t     popped_q;
  word_t     popped_d;
  status_e   status_q;
  status_e   status_d;
  count_t    out_count_q;
  logic      accept;
  logic      is_full;
  logic      is_empty;
  cell_cmd_t cmd;

  word_t     entry   [Depth];
  word_t     tail    [Depth+1];
  logic      found   [Depth+1];
  cell_pos_t pos     [Depth];

  assign accept   = in_i.valid && in_i.ready;
  assign is_full  = (count_q == count_t'(Depth));
  assign is_empty = (count_q == '0);

  assign in_i.ready         = !out_valid_q || out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.status       = status_q;
  assign out_o.count        = out_count_q;

  assign tail[0]  = '0;
  assign found[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign pos[i].occupied = (count_t'(i) < count_q);
    assign pos[i].at_count = (count_q == count_t'(i));
    assign pos[i].is_last  = (count_q == count_t'(i + 1));

    dwsi_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .pos_i         (pos[i]),
      .left_entry_i  ((i == 0) ? cmd.value : entry[(i == 0) ? 0 : i - 1]),
      .right_entry_i ((i == Depth - 1) ? entry[i] : entry[(i == Depth - 1) ? i : i + 1]),
      .found_i       (found[i]),
      .found_o       (found[i+1]),
      .tail_i        (tail[i]),
      .tail_o        (tail[i+1]),
      .entry_o       (entry[i])
    );
  end

  always_comb begin
    cmd.op     = CmdHold;
    cmd.sorted = (in_i.action == ActInsert);
    cmd.value  = in_i.value;
    count_d    = count_q;
    popped_d   = '0;
    status_d   = StOk;
    unique case (in_i.action)
      ActAppend, ActInsert: begin
        if (is_full) begin
          status_d = StFull;
        end else begin
          cmd.op  = accept ? CmdInsert : CmdHold;
          count_d = count_q + count_t'(1);
        end
      end
      ActPopFront: begin
        if (is_empty) begin
          status_d = StEmpty;
        end else begin
          cmd.op   = accept ? CmdShiftOut : CmdHold;
          popped_d = entry[0];
          count_d  = count_q - count_t'(1);
        end
      end
      ActPopBack: begin
        if (is_empty) begin
          status_d = StEmpty;
        end else begin
          popped_d = tail[Depth];
          count_d  = count_q - count_t'(1);
        end
      end
      default: status_d = StOk;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q    <= popped_d;
      status_q    <= status_d;
      out_count_q <= count_d;
    end
  end

endmodule
